// ===== sv/rbti_pkg.sv =====
// Shared types, constants and helpers for the rigid body trapezoid integrator.
// Used by the register file, controller, datapath and top level.
`default_nettype none

package rbti_pkg;

   // Register indexes (word address of the configuration port)
   typedef enum logic [2:0] {
      REG_INVERSE_MASS,
      REG_CONSTRAIN,
      REG_AXIS_X,
      REG_AXIS_Y,
      REG_INIT_POS_X,
      REG_INIT_POS_Y,
      REG_INIT_VEL_X,
      REG_INIT_VEL_Y
   } reg_index_type;

   localparam logic [31:0] INVERSE_MASS_RESET = 32'h0001_0000;
   localparam logic [15:0] AXIS_X_RESET       = 16'h4000;

   // Configuration registers as seen by the datapath and controller
   typedef struct packed {
      logic        [31:0] inverse_mass;
      logic               constrain_enable;
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic signed [31:0] init_pos_x;
      logic signed [31:0] init_pos_y;
      logic signed [31:0] init_vel_x;
      logic signed [31:0] init_vel_y;
   } cfg_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DOT0,
      ST_DOT1,
      ST_DOT2,
      ST_PRJX,
      ST_PRJY,
      ST_PJY,
      ST_AXH,
      ST_AXL,
      ST_AYH,
      ST_AYL,
      ST_VX,
      ST_VY,
      ST_PX,
      ST_PY,
      ST_PW,
      ST_RLD,
      ST_DONE
   } state_type;

   // Operand pair fed to the shared multiplier
   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_FX_AX,
      MUL_FY_AY,
      MUL_D_AX,
      MUL_D_AY,
      MUL_FX_IMH,
      MUL_FX_IML,
      MUL_FY_IMH,
      MUL_FY_IML,
      MUL_VX,
      MUL_VY,
      MUL_PX,
      MUL_PY
   } mul_sel_type;

   // Destination of the registered product
   typedef enum logic [3:0] {
      WB_NONE,
      WB_D_LOAD,
      WB_D_ADD,
      WB_FX_PRJ,
      WB_FY_PRJ,
      WB_S,
      WB_ACCX,
      WB_ACCY,
      WB_VELX,
      WB_VELY,
      WB_POSX,
      WB_POSY,
      WB_RESTART
   } wb_sel_type;

   typedef struct packed {
      logic        load;
      mul_sel_type mul;
      wb_sel_type  wb;
   } cmd_type;

   typedef struct packed {
      logic               clip;
      logic signed [31:0] val;
   } sat_type;

   localparam logic signed [65:0] Q_MAX   = 66'sh0_7FFF_FFFF;
   localparam logic signed [65:0] Q_MIN   = ~Q_MAX;
   localparam logic signed [65:0] HALF_16 = 66'sd32768;
   localparam logic signed [65:0] HALF_17 = 66'sd65536;
   localparam logic signed [65:0] HALF_28 = 66'sd134217728;

   function automatic sat_type sat32(input logic signed [65:0] v);
      sat_type r;
      if (v > Q_MAX) begin
         r.clip = 1'b1;
         r.val  = Q_MAX[31:0];
      end else if (v < Q_MIN) begin
         r.clip = 1'b1;
         r.val  = Q_MIN[31:0];
      end else begin
         r.clip = 1'b0;
         r.val  = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/rigid_body_trapezoid_integrator.sv =====
// Rigid body trapezoid integrator, top level: register file, controller, datapath.
// Integrate and restart items each pass through the controller's steps, with the
// projection onto the axis in front when the constraint is on. One item at a time
// through the single shared multiplier; the next item is taken in the cycle the
// result is taken.
// Synchronous reset clears the motion state to zero and the registers to their
// defaults (inverse mass 1.0, axis (1,0), constraint off).
`default_nettype none

module rigid_body_trapezoid_integrator (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [79:0]  req_tdata,   // force_x, force_y, time_step
   input  wire          req_tuser,   // operation
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [191:0] rsp_tdata,   // pos_x, pos_y, vel_x, vel_y, acc_x, acc_y
   output logic         rsp_tuser,   // saturated
   input  wire          csr_psel,
   input  wire          csr_penable,
   input  wire          csr_pwrite,
   input  wire  [4:0]   csr_paddr,
   input  wire  [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import rbti_pkg::*;

   cfg_type            cfg;
   cmd_type            cmd;
   logic signed [31:0] pos_x, pos_y, vel_x, vel_y, acc_x, acc_y;

   rbti_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rbti_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .constrain  (cfg.constrain_enable),
      .rsp_tready (rsp_tready),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd)
   );

   rbti_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cfg       (cfg),
      .operation (req_tuser),
      .force_x   (req_tdata[31:0]),
      .force_y   (req_tdata[63:32]),
      .time_step (req_tdata[79:64]),
      .pos_x_out (pos_x),
      .pos_y_out (pos_y),
      .vel_x_out (vel_x),
      .vel_y_out (vel_y),
      .acc_x_out (acc_x),
      .acc_y_out (acc_y),
      .saturated (rsp_tuser)
   );

   assign rsp_tdata = {acc_y, acc_x, vel_y, vel_x, pos_y, pos_x};

endmodule

`default_nettype wire

// ===== sv/rbti_csr.sv =====
// Configuration register file behind the APB-style port.
// Depends on rbti_pkg for register indexes and the cfg_type struct.
`default_nettype none

module rbti_csr (
   input  wire               clock,
   input  wire               reset,
   input  wire               csr_psel,
   input  wire               csr_penable,
   input  wire               csr_pwrite,
   input  wire        [4:0]  csr_paddr,
   input  wire        [31:0] csr_pwdata,
   output logic       [31:0] csr_prdata,
   output logic              csr_pready,
   output rbti_pkg::cfg_type cfg
);
   import rbti_pkg::*;

   logic        [31:0] inverse_mass_ff, inverse_mass_in;
   logic               constrain_ff, constrain_in;
   logic signed [15:0] axis_x_ff, axis_x_in;
   logic signed [15:0] axis_y_ff, axis_y_in;
   logic signed [31:0] init_pos_x_ff, init_pos_x_in;
   logic signed [31:0] init_pos_y_ff, init_pos_y_in;
   logic signed [31:0] init_vel_x_ff, init_vel_x_in;
   logic signed [31:0] init_vel_y_ff, init_vel_y_in;
   logic               wr_en;
   reg_index_type      index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign index      = reg_index_type'(csr_paddr[4:2]);

   always_comb begin
      inverse_mass_in = inverse_mass_ff;
      constrain_in    = constrain_ff;
      axis_x_in       = axis_x_ff;
      axis_y_in       = axis_y_ff;
      init_pos_x_in   = init_pos_x_ff;
      init_pos_y_in   = init_pos_y_ff;
      init_vel_x_in   = init_vel_x_ff;
      init_vel_y_in   = init_vel_y_ff;
      if (wr_en) begin
         case (index)
            REG_INVERSE_MASS: inverse_mass_in = csr_pwdata;
            REG_CONSTRAIN:    constrain_in    = csr_pwdata[0];
            REG_AXIS_X:       axis_x_in       = csr_pwdata[15:0];
            REG_AXIS_Y:       axis_y_in       = csr_pwdata[15:0];
            REG_INIT_POS_X:   init_pos_x_in   = csr_pwdata;
            REG_INIT_POS_Y:   init_pos_y_in   = csr_pwdata;
            REG_INIT_VEL_X:   init_vel_x_in   = csr_pwdata;
            REG_INIT_VEL_Y:   init_vel_y_in   = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inverse_mass_ff <= INVERSE_MASS_RESET;
         constrain_ff    <= 1'b0;
         axis_x_ff       <= AXIS_X_RESET;
         axis_y_ff       <= '0;
         init_pos_x_ff   <= '0;
         init_pos_y_ff   <= '0;
         init_vel_x_ff   <= '0;
         init_vel_y_ff   <= '0;
      end else begin
         inverse_mass_ff <= inverse_mass_in;
         constrain_ff    <= constrain_in;
         axis_x_ff       <= axis_x_in;
         axis_y_ff       <= axis_y_in;
         init_pos_x_ff   <= init_pos_x_in;
         init_pos_y_ff   <= init_pos_y_in;
         init_vel_x_ff   <= init_vel_x_in;
         init_vel_y_ff   <= init_vel_y_in;
      end
   end

   always_comb begin
      case (index)
         REG_INVERSE_MASS: csr_prdata = inverse_mass_ff;
         REG_CONSTRAIN:    csr_prdata = {31'b0, constrain_ff};
         REG_AXIS_X:       csr_prdata = {16'b0, axis_x_ff};
         REG_AXIS_Y:       csr_prdata = {16'b0, axis_y_ff};
         REG_INIT_POS_X:   csr_prdata = init_pos_x_ff;
         REG_INIT_POS_Y:   csr_prdata = init_pos_y_ff;
         REG_INIT_VEL_X:   csr_prdata = init_vel_x_ff;
         REG_INIT_VEL_Y:   csr_prdata = init_vel_y_ff;
         default:          csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.inverse_mass     = inverse_mass_ff;
      cfg.constrain_enable = constrain_ff;
      cfg.axis_x           = axis_x_ff;
      cfg.axis_y           = axis_y_ff;
      cfg.init_pos_x       = init_pos_x_ff;
      cfg.init_pos_y       = init_pos_y_ff;
      cfg.init_vel_x       = init_vel_x_ff;
      cfg.init_vel_y       = init_vel_y_ff;
   end

endmodule

`default_nettype wire

// ===== sv/rbti_ctrl.sv =====
// Sequencing state machine: steps the shared multiplier through one item.
// Depends on rbti_pkg for state_type and cmd_type.
`default_nettype none

module rbti_ctrl (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_tvalid,
   input  wire               req_tuser,
   input  wire               constrain,
   input  wire               rsp_tready,
   output logic              req_tready,
   output logic              rsp_tvalid,
   output rbti_pkg::cmd_type cmd
);
   import rbti_pkg::*;

   state_type state_ff, state_in;
   logic      op_ff, op_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      cmd.load   = 1'b0;
      cmd.mul    = MUL_NONE;
      cmd.wb     = WB_NONE;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         // dot product of the vector with the axis
         ST_DOT0: begin
            cmd.mul  = MUL_FX_AX;
            state_in = ST_DOT1;
         end
         ST_DOT1: begin
            cmd.mul  = MUL_FY_AY;
            cmd.wb   = WB_D_LOAD;
            state_in = ST_DOT2;
         end
         ST_DOT2: begin
            cmd.wb   = WB_D_ADD;
            state_in = ST_PRJX;
         end
         ST_PRJX: begin
            cmd.mul  = MUL_D_AX;
            state_in = ST_PRJY;
         end
         ST_PRJY: begin
            cmd.mul  = MUL_D_AY;
            cmd.wb   = WB_FX_PRJ;
            state_in = op_ff ? ST_PJY : ST_AXH;
         end
         ST_PJY: begin
            cmd.wb   = WB_FY_PRJ;
            state_in = ST_RLD;
         end
         // acceleration: force times inverse mass in two 16-bit halves
         ST_AXH: begin
            cmd.mul  = MUL_FX_IMH;
            cmd.wb   = constrain ? WB_FY_PRJ : WB_NONE;
            state_in = ST_AXL;
         end
         ST_AXL: begin
            cmd.mul  = MUL_FX_IML;
            cmd.wb   = WB_S;
            state_in = ST_AYH;
         end
         ST_AYH: begin
            cmd.mul  = MUL_FY_IMH;
            cmd.wb   = WB_ACCX;
            state_in = ST_AYL;
         end
         ST_AYL: begin
            cmd.mul  = MUL_FY_IML;
            cmd.wb   = WB_S;
            state_in = ST_VX;
         end
         // trapezoid updates of velocity, then position
         ST_VX: begin
            cmd.mul  = MUL_VX;
            cmd.wb   = WB_ACCY;
            state_in = ST_VY;
         end
         ST_VY: begin
            cmd.mul  = MUL_VY;
            cmd.wb   = WB_VELX;
            state_in = ST_PX;
         end
         ST_PX: begin
            cmd.mul  = MUL_PX;
            cmd.wb   = WB_VELY;
            state_in = ST_PY;
         end
         ST_PY: begin
            cmd.mul  = MUL_PY;
            cmd.wb   = WB_POSX;
            state_in = ST_PW;
         end
         ST_PW: begin
            cmd.wb   = WB_POSY;
            state_in = ST_DONE;
         end
         ST_RLD: begin
            cmd.wb   = WB_RESTART;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_tvalid = 1'b1;
            req_tready = rsp_tready;
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // take the next item in the cycle the previous result leaves
      if (req_tready && req_tvalid) begin
         cmd.load = 1'b1;
         op_in    = req_tuser;
         if (constrain) begin
            state_in = ST_DOT0;
         end else begin
            state_in = req_tuser ? ST_RLD : ST_AXH;
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/rbti_dp.sv =====
// Datapath: motion state, working registers and one shared 49x17 multiplier.
// Depends on rbti_pkg for cfg_type, cmd_type, rounding constants and sat32.
`default_nettype none

module rbti_dp (
   input  wire                clock,
   input  wire                reset,
   input  rbti_pkg::cmd_type  cmd,
   input  rbti_pkg::cfg_type  cfg,
   input  wire                operation,
   input  wire signed  [31:0] force_x,
   input  wire signed  [31:0] force_y,
   input  wire         [15:0] time_step,
   output logic signed [31:0] pos_x_out,
   output logic signed [31:0] pos_y_out,
   output logic signed [31:0] vel_x_out,
   output logic signed [31:0] vel_y_out,
   output logic signed [31:0] acc_x_out,
   output logic signed [31:0] acc_y_out,
   output logic               saturated
);
   import rbti_pkg::*;

   // architectural state
   logic signed [31:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [31:0] vel_x_ff, vel_x_in, vel_y_ff, vel_y_in;
   logic signed [31:0] acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic               sat_ff, sat_in;
   // working registers
   logic signed [31:0] f_x_ff, f_x_in, f_y_ff, f_y_in;
   logic signed [31:0] a0_x_ff, a0_x_in, a0_y_ff, a0_y_in;
   logic signed [31:0] v0_x_ff, v0_x_in, v0_y_ff, v0_y_in;
   logic        [15:0] dt_ff, dt_in;
   logic signed [48:0] d_ff, d_in;
   logic signed [65:0] s_ff, s_in;
   logic signed [65:0] p_ff, p_in;

   logic signed [48:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [32:0] pair_sum;
   logic signed [65:0] pre;
   sat_type            sat_r;

   always_comb begin
      mul_a    = '0;
      mul_b    = '0;
      pair_sum = '0;
      case (cmd.mul)
         MUL_NONE: ;
         MUL_FX_AX: begin
            mul_a = 49'(f_x_ff);
            mul_b = 17'(cfg.axis_x);
         end
         MUL_FY_AY: begin
            mul_a = 49'(f_y_ff);
            mul_b = 17'(cfg.axis_y);
         end
         MUL_D_AX: begin
            mul_a = d_ff;
            mul_b = 17'(cfg.axis_x);
         end
         MUL_D_AY: begin
            mul_a = d_ff;
            mul_b = 17'(cfg.axis_y);
         end
         MUL_FX_IMH: begin
            mul_a = 49'(f_x_ff);
            mul_b = signed'({1'b0, cfg.inverse_mass[31:16]});
         end
         MUL_FX_IML: begin
            mul_a = 49'(f_x_ff);
            mul_b = signed'({1'b0, cfg.inverse_mass[15:0]});
         end
         MUL_FY_IMH: begin
            mul_a = 49'(f_y_ff);
            mul_b = signed'({1'b0, cfg.inverse_mass[31:16]});
         end
         MUL_FY_IML: begin
            mul_a = 49'(f_y_ff);
            mul_b = signed'({1'b0, cfg.inverse_mass[15:0]});
         end
         MUL_VX: begin
            pair_sum = 33'(acc_x_ff) + 33'(a0_x_ff);
            mul_a    = 49'(pair_sum);
            mul_b    = signed'({1'b0, dt_ff});
         end
         MUL_VY: begin
            pair_sum = 33'(acc_y_ff) + 33'(a0_y_ff);
            mul_a    = 49'(pair_sum);
            mul_b    = signed'({1'b0, dt_ff});
         end
         MUL_PX: begin
            pair_sum = 33'(vel_x_ff) + 33'(v0_x_ff);
            mul_a    = 49'(pair_sum);
            mul_b    = signed'({1'b0, dt_ff});
         end
         MUL_PY: begin
            pair_sum = 33'(vel_y_ff) + 33'(v0_y_ff);
            mul_a    = 49'(pair_sum);
            mul_b    = signed'({1'b0, dt_ff});
         end
         default: ;
      endcase
   end

   assign p_in = mul_a * mul_b;

   // round half up, add to the base where there is one, then clip
   always_comb begin
      pre = '0;
      case (cmd.wb)
         WB_FX_PRJ, WB_FY_PRJ: pre = (p_ff + HALF_28) >>> 28;
         WB_ACCX, WB_ACCY:     pre = (s_ff + p_ff + HALF_16) >>> 16;
         WB_VELX:              pre = 66'(vel_x_ff) + ((p_ff + HALF_17) >>> 17);
         WB_VELY:              pre = 66'(vel_y_ff) + ((p_ff + HALF_17) >>> 17);
         WB_POSX:              pre = 66'(pos_x_ff) + ((p_ff + HALF_17) >>> 17);
         WB_POSY:              pre = 66'(pos_y_ff) + ((p_ff + HALF_17) >>> 17);
         default:              pre = '0;
      endcase
      sat_r = sat32(pre);
   end

   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      vel_x_in = vel_x_ff;
      vel_y_in = vel_y_ff;
      acc_x_in = acc_x_ff;
      acc_y_in = acc_y_ff;
      f_x_in   = f_x_ff;
      f_y_in   = f_y_ff;
      a0_x_in  = a0_x_ff;
      a0_y_in  = a0_y_ff;
      v0_x_in  = v0_x_ff;
      v0_y_in  = v0_y_ff;
      dt_in    = dt_ff;
      d_in     = d_ff;
      s_in     = s_ff;
      sat_in   = sat_ff | sat_r.clip;
      case (cmd.wb)
         WB_NONE: ;
         WB_D_LOAD:  d_in     = p_ff[48:0];
         WB_D_ADD:   d_in     = d_ff + p_ff[48:0];
         WB_FX_PRJ:  f_x_in   = sat_r.val;
         WB_FY_PRJ:  f_y_in   = sat_r.val;
         WB_S:       s_in     = p_ff <<< 16;
         WB_ACCX:    acc_x_in = sat_r.val;
         WB_ACCY:    acc_y_in = sat_r.val;
         WB_VELX:    vel_x_in = sat_r.val;
         WB_VELY:    vel_y_in = sat_r.val;
         WB_POSX:    pos_x_in = sat_r.val;
         WB_POSY:    pos_y_in = sat_r.val;
         WB_RESTART: begin
            pos_x_in = cfg.init_pos_x;
            pos_y_in = cfg.init_pos_y;
            vel_x_in = f_x_ff;
            vel_y_in = f_y_ff;
            acc_x_in = '0;
            acc_y_in = '0;
         end
         default: ;
      endcase
      // capture the item and snapshot the previous acceleration and velocity
      if (cmd.load) begin
         f_x_in  = operation ? cfg.init_vel_x : force_x;
         f_y_in  = operation ? cfg.init_vel_y : force_y;
         dt_in   = time_step;
         a0_x_in = acc_x_ff;
         a0_y_in = acc_y_ff;
         v0_x_in = vel_x_ff;
         v0_y_in = vel_y_ff;
         sat_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         vel_x_ff <= '0;
         vel_y_ff <= '0;
         acc_x_ff <= '0;
         acc_y_ff <= '0;
         sat_ff   <= 1'b0;
      end else begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         vel_x_ff <= vel_x_in;
         vel_y_ff <= vel_y_in;
         acc_x_ff <= acc_x_in;
         acc_y_ff <= acc_y_in;
         sat_ff   <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      f_x_ff  <= f_x_in;
      f_y_ff  <= f_y_in;
      a0_x_ff <= a0_x_in;
      a0_y_ff <= a0_y_in;
      v0_x_ff <= v0_x_in;
      v0_y_ff <= v0_y_in;
      dt_ff   <= dt_in;
      d_ff    <= d_in;
      s_ff    <= s_in;
      p_ff    <= p_in;
   end

   assign pos_x_out = pos_x_ff;
   assign pos_y_out = pos_y_ff;
   assign vel_x_out = vel_x_ff;
   assign vel_y_out = vel_y_ff;
   assign acc_x_out = acc_x_ff;
   assign acc_y_out = acc_y_ff;
   assign saturated = sat_ff;

endmodule

`default_nettype wire

// ===== sv/rbti_checker.sv =====
// Port-level checks for the rigid body trapezoid integrator, bound to its top.
// Needs only the top level's ports.
`default_nettype none

module rbti_checker (
   input wire         clock,
   input wire         reset,
   input wire         req_tvalid,
   input wire         req_tready,
   input wire         req_tuser,
   input wire         rsp_tvalid,
   input wire         rsp_tready,
   input wire [191:0] rsp_tdata,
   input wire         rsp_tuser
);

   logic last_restart_ff, last_restart_in;

   assign last_restart_in = (req_tvalid && req_tready) ? req_tuser : last_restart_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_restart_ff <= 1'b0;
      end else begin
         last_restart_ff <= last_restart_in;
      end
   end

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // no result can be shown in the cycle right after an item is taken
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !rsp_tvalid)
      else $error("result appeared without compute time");

   // a held result blocks new items
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("item taken while a result is pending");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // restart clears the acceleration
   a_restart_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && last_restart_ff |-> rsp_tdata[191:128] == 64'd0)
      else $error("acceleration not cleared by restart");

endmodule

bind rigid_body_trapezoid_integrator rbti_checker u_rbti_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
